[hdl/sha256_pkg.sv]
`default_nettype none

package sha256_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned FILL_W  = 6;
    localparam int unsigned ROUND_W = 6;
    localparam int unsigned LEN_W   = 64;

    localparam logic [BYTE_W-1:0]  PAD_BYTE   = 8'h80;
    localparam logic [FILL_W-1:0]  LEN_OFFSET = 6'd56;
    localparam logic [FILL_W-1:0]  LAST_FILL  = 6'd63;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;
    localparam logic [IDX_W-1:0]   LAST_WORD  = 3'd7;

    localparam logic [0:7][WORD_W-1:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][WORD_W-1:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [1:0] {
        SEL_IN,
        SEL_PAD80,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_FINAL,
        ST_PAD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               push;
        t_byte_sel          byte_sel;
        logic               count_bits;
        logic               load_work;
        logic               round;
        logic [ROUND_W-1:0] round_idx;
        logic               final_add;
        logic               clear_msg;
        logic [IDX_W-1:0]   out_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
    } t_dp_stat;

endpackage

`default_nettype wire

[hdl/sha256_dpath.sv]
`default_nettype none

module sha256_dpath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire sha256_pkg::t_dp_cmd       i_cmd,
    input  wire logic [7:0]                i_data_byte,
    output sha256_pkg::t_dp_stat           o_stat,
    output logic [31:0]                    o_digest_word
);
    import sha256_pkg::*;

    function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] x, input int unsigned n);
        ror = (x >> n) | (x << (WORD_W - n));
    endfunction

    // 16-word window: block buffer while filling, message schedule while compressing
    logic [WORD_W-1:0] r_w [16];
    logic [WORD_W-1:0] n_w [16];
    logic [WORD_W-1:0] r_h [8];
    logic [WORD_W-1:0] r_v [8];
    logic [FILL_W-1:0] r_fill;
    logic [LEN_W-1:0]  r_bits;

    logic [BYTE_W-1:0] push_byte;
    logic [BYTE_W-1:0] len_byte;
    logic [WORD_W-1:0] sig0_w, sig1_w, w_next;
    logic [WORD_W-1:0] big0, big1, ch, maj, t1, t2;

    always_comb begin
        len_byte = '0;
        for (int i = 0; i < 8; i++) begin
            if (r_fill[2:0] == 3'(i)) begin
                len_byte = r_bits[LEN_W-1-8*i -: 8];
            end
        end
    end

    always_comb begin
        unique case (i_cmd.byte_sel)
            SEL_IN:    push_byte = i_data_byte;
            SEL_PAD80: push_byte = PAD_BYTE;
            SEL_ZERO:  push_byte = '0;
            SEL_LEN:   push_byte = len_byte;
        endcase
    end

    // schedule expansion on fixed window taps
    always_comb begin
        sig0_w = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
        sig1_w = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
        w_next = r_w[0] + sig0_w + r_w[9] + sig1_w;
    end

    // round function
    always_comb begin
        big1 = ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25);
        ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        big0 = ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22);
        maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1   = r_v[7] + big1 + ch + ROUND_K[i_cmd.round_idx] + r_w[0];
        t2   = big0 + maj;
    end

    always_comb begin
        for (int j = 0; j < 16; j++) begin
            n_w[j] = r_w[j];
        end
        if (i_cmd.round) begin
            for (int j = 0; j < 15; j++) begin
                n_w[j] = r_w[j+1];
            end
            n_w[15] = w_next;
        end else if (i_cmd.push) begin
            for (int j = 0; j < 16; j++) begin
                for (int b = 0; b < 4; b++) begin
                    if (r_fill == FILL_W'(4 * j + b)) begin
                        n_w[j][WORD_W-1-8*b -: 8] = push_byte;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 16; j++) begin
            r_w[j] <= n_w[j];
        end
        if (i_cmd.load_work) begin
            for (int j = 0; j < 8; j++) begin
                r_v[j] <= r_h[j];
            end
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_msg) begin
            for (int j = 0; j < 8; j++) begin
                r_h[j] <= INIT_HASH[j];
            end
            r_fill <= '0;
            r_bits <= '0;
        end else begin
            if (i_cmd.final_add) begin
                for (int j = 0; j < 8; j++) begin
                    r_h[j] <= r_h[j] + r_v[j];
                end
            end
            if (i_cmd.push) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.count_bits) begin
                r_bits <= r_bits + LEN_W'(8);
            end
        end
    end

    assign o_stat.fill   = r_fill;
    assign o_digest_word = r_h[i_cmd.out_idx];

endmodule

`default_nettype wire

[hdl/sha256_ctrl.sv]
`default_nettype none

module sha256_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_has_byte,
    input  wire logic                 i_end_of_message,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [2:0]                o_word_index,
    output logic                      o_last_word,
    output sha256_pkg::t_dp_cmd       o_cmd,
    input  wire sha256_pkg::t_dp_stat i_stat
);
    import sha256_pkg::*;

    t_state             r_state, n_state;
    logic [ROUND_W-1:0] r_round, n_round;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_need80, n_need80;
    logic               r_len, n_len;
    logic               r_pad, n_pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_round  <= '0;
            r_idx    <= '0;
            r_need80 <= 1'b0;
            r_len    <= 1'b0;
            r_pad    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_round  <= n_round;
            r_idx    <= n_idx;
            r_need80 <= n_need80;
            r_len    <= n_len;
            r_pad    <= n_pad;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_idx       = r_idx;
        n_need80    = r_need80;
        n_len       = r_len;
        n_pad       = r_pad;
        o_cmd       = '0;
        o_cmd.byte_sel  = SEL_IN;
        o_cmd.round_idx = r_round;
        o_cmd.out_idx   = r_idx;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_has_byte) begin
                        o_cmd.push       = 1'b1;
                        o_cmd.count_bits = 1'b1;
                    end
                    if (i_end_of_message) begin
                        n_pad    = 1'b1;
                        n_need80 = 1'b1;
                    end
                    if (i_has_byte && i_stat.fill == LAST_FILL) begin
                        o_cmd.load_work = 1'b1;
                        n_round         = '0;
                        n_state         = ST_COMP;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_COMP: begin
                o_cmd.round = 1'b1;
                n_round     = r_round + 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                o_cmd.final_add = 1'b1;
                n_idx           = '0;
                if (r_len) begin
                    n_state = ST_EMIT;
                end else if (r_pad) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                o_cmd.push = 1'b1;
                if (r_need80) begin
                    o_cmd.byte_sel = SEL_PAD80;
                    n_need80       = 1'b0;
                end else if (r_len || i_stat.fill == LEN_OFFSET) begin
                    o_cmd.byte_sel = SEL_LEN;
                    n_len          = 1'b1;
                end else begin
                    o_cmd.byte_sel = SEL_ZERO;
                end
                if (i_stat.fill == LAST_FILL) begin
                    o_cmd.load_work = 1'b1;
                    n_round         = '0;
                    n_state         = ST_COMP;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == LAST_WORD) begin
                        o_cmd.clear_msg = 1'b1;
                        n_pad           = 1'b0;
                        n_len           = 1'b0;
                        n_state         = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == LAST_WORD);

endmodule

`default_nettype wire

[hdl/sha256_hash_engine_unit.sv]
// a plain byte transaction is taken with one push; a byte that completes a 64-byte block
// also runs a compression (push, 64 rounds on the single round unit, hash update)
// end of message: 9 to 72 padding bytes at one per cycle outside compressions, one or two
// compressions, then 8 digest words at one per cycle when the sink is ready
// throughput: one message at a time, rate set by the one-round-per-cycle compression loop
// reset: synchronous active low, loads the initial hash values and clears fill and bit count
`default_nettype none

module sha256_hash_engine_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,   // end_of_message
    // digest stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast    // last_word
);
    import sha256_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: byte intake, padding, round count, digest output
    sha256_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (s_axis_tvalid),
        .o_in_ready       (s_axis_tready),
        .i_has_byte       (s_axis_tuser),
        .i_end_of_message (s_axis_tlast),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_word_index     (m_axis_tuser),
        .o_last_word      (m_axis_tlast),
        .o_cmd            (cmd),
        .i_stat           (stat)
    );

    // datapath: block window, schedule, working variables, hash words, bit count
    sha256_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (s_axis_tdata),
        .o_stat        (stat),
        .o_digest_word (m_axis_tdata)
    );

endmodule

`default_nettype wire

[bench/sha256_digest_checker.sv]
`timescale 1ns / 1ps

module sha256_digest_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic        i_s_tuser,   // [0] has_byte
    input  wire logic        i_s_tlast,   // end_of_message
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,   // [31:0] digest_word
    input  wire logic [2:0]  i_m_tuser,   // [2:0] word_index
    input  wire logic        i_m_tlast,   // last_word
    output int unsigned      o_error_count,
    output int unsigned      o_words_pending,
    output int unsigned      o_words_checked
);

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [5:0] LENGTH_POS   = 6'd56;
    localparam logic [5:0] BLOCK_END    = 6'd63;
    localparam logic [2:0] FINAL_INDEX  = 3'd7;

    localparam logic [0:7][31:0] IV_WORDS = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic [31:0]  hash_acc [0:7];
    logic [7:0]   block_buf [0:63];
    logic [5:0]   block_fill;
    logic [63:0]  msg_bits;
    t_digest_word digest_words_due [$];

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void clear_message();
        for (int j = 0; j < 8; j++) hash_acc[j] = IV_WORDS[j];
        for (int j = 0; j < 64; j++) block_buf[j] = 8'h00;
        block_fill = 6'd0;
        msg_bits   = 64'd0;
    endfunction

    // one 64-round compression of block_buf into hash_acc
    function automatic void compress_block();
        logic [31:0] w [0:15];
        logic [31:0] v [0:7];
        logic [31:0] x15, x2, s0, s1, wr, t1, t2;
        for (int j = 0; j < 16; j++)
            w[j] = {block_buf[4*j], block_buf[4*j+1], block_buf[4*j+2], block_buf[4*j+3]};
        for (int j = 0; j < 8; j++) v[j] = hash_acc[j];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wr = w[r];
            end else begin
                x15 = w[(r - 15) % 16];
                x2  = w[(r - 2) % 16];
                s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
                s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
                wr  = w[r % 16] + s0 + w[(r - 7) % 16] + s1;
                w[r % 16] = wr;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + wr;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) hash_acc[j] = hash_acc[j] + v[j];
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        block_buf[block_fill] = b;
        if (block_fill == BLOCK_END) begin
            compress_block();
            block_fill = 6'd0;
        end else begin
            block_fill = block_fill + 6'd1;
        end
    endfunction

    // pad, append the bit length, queue the eight digest words, restart
    function automatic void finish_message();
        logic [63:0]  bit_len;
        t_digest_word d;
        bit_len = msg_bits;
        absorb_byte(PAD_MARK);
        while (block_fill != LENGTH_POS) absorb_byte(8'h00);
        for (int i = 0; i < 8; i++) absorb_byte(bit_len[63 - 8*i -: 8]);
        for (int i = 0; i < 8; i++) begin
            d.word  = hash_acc[i];
            d.index = 3'(i);
            d.last  = (3'(i) == FINAL_INDEX);
            digest_words_due = {digest_words_due, d};
        end
        clear_message();
    endfunction

    function automatic void check_word();
        t_digest_word d;
        if (digest_words_due.size() == 0) begin
            o_error_count = o_error_count + 1;
            $display("%0t: unexpected digest word: got word %h index %0d last %0b",
                     $time, i_m_tdata, i_m_tuser, i_m_tlast);
        end else begin
            d = digest_words_due.pop_front();
            o_words_checked = o_words_checked + 1;
            if (d.word !== i_m_tdata || d.index !== i_m_tuser || d.last !== i_m_tlast) begin
                o_error_count = o_error_count + 1;
                $display("%0t: digest mismatch: expected word %h index %0d last %0b,",
                         $time, d.word, d.index, d.last);
                $display("    got word %h index %0d last %0b",
                         i_m_tdata, i_m_tuser, i_m_tlast);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_message();
            digest_words_due.delete();
            o_error_count   = 0;
            o_words_checked = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                // a byte carried with the end mark belongs to the message
                if (i_s_tuser) begin
                    msg_bits = msg_bits + 64'd8;
                    absorb_byte(i_s_tdata);
                end
                if (i_s_tlast) finish_message();
            end
            if (i_m_tvalid && i_m_tready) check_word();
        end
        o_words_pending = digest_words_due.size();
    end

endmodule

[bench/tb_sha256_hash_engine_unit.sv]
`timescale 1ns / 1ps

module tb_sha256_hash_engine_unit;

    // run size, counted in all input transactions, directed and ignored ones included
    localparam int unsigned ITEM_TARGET    = 160;
    // a long message needs this much room left in the run, bytes plus end and noise
    localparam int unsigned LONG_ROOM      = 80;
    // quiet-cycle limit: worst end of message is about 72 pad bytes plus two
    // compressions, then eight words behind a heavily stalled sink
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    // settle time after the last digest word, above one full end-of-message pass
    localparam int unsigned DRAIN_CYCLES   = 250;

    logic        i_clk;
    logic        i_rst_n;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] data_byte
    logic        s_axis_tuser;    // [0] has_byte
    logic        s_axis_tlast;    // end_of_message

    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [31:0] digest_word
    logic [2:0]  m_axis_tuser;    // [2:0] word_index
    logic        m_axis_tlast;    // last_word

    int unsigned error_count;
    int unsigned words_pending;
    int unsigned words_checked;

    // idle percentages of the source and the sink, changed per phase
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;

    int unsigned items_sent;      // transactions with a byte or an end mark
    int unsigned noise_sent;      // transactions the block should ignore
    int unsigned messages_sent;

    sha256_hash_engine_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // watches both streams, predicts every digest word and compares in order
    sha256_digest_checker digest_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tuser       (s_axis_tuser),
        .i_s_tlast       (s_axis_tlast),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tuser       (m_axis_tuser),
        .i_m_tlast       (m_axis_tlast),
        .o_error_count   (error_count),
        .o_words_pending (words_pending),
        .o_words_checked (words_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // sink backpressure, redrawn every cycle at the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // watchdog: counts cycles without a transaction on either stream
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("%0t: watchdog expired, %0d digest words still outstanding",
                 $time, words_pending);
        $display("Verification failed");
        $finish;
    end

    // one input transaction; called and returning at a falling edge
    task automatic send_item(input logic [7:0] b, input logic has_b, input logic eom);
        // random gap before the transaction, valid dropped for its length
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= has_b;
        s_axis_tlast  <= eom;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (has_b || eom)
            items_sent = items_sent + 1;
        else
            noise_sent = noise_sent + 1;
    endtask

    // a message of random bytes; the end mark rides on the last byte or follows it
    task automatic send_message(input int unsigned len);
        bit joint;
        joint = (len != 0) && ($urandom_range(1) == 1);
        for (int unsigned n = 0; n < len; n++) begin
            if ($urandom_range(9) == 0)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, joint && (n == len - 1));
        end
        if (!joint)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        messages_sent = messages_sent + 1;
    endtask

    initial begin : stimulus
        int unsigned len;
        int unsigned total;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        src_idle_pct  = 31;
        snk_idle_pct  = 70;
        items_sent    = 0;
        noise_sent    = 0;
        messages_sent = 0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: ignored item with all data bits set, then empty messages back to back
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);
        messages_sent = messages_sent + 2;
        // single zero byte carried together with the end mark
        send_item(8'h00, 1'b1, 1'b1);
        // single all-ones byte, end mark on its own, ignored item in between
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        // the classic three-byte text, last byte with the end mark
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        messages_sent = messages_sent + 3;

        // random: mostly short messages, some at the padding and block boundaries
        // (55 fits one pad block, 56 and 63 need two, 64 fills a block first)
        while (items_sent + noise_sent < ITEM_TARGET) begin
            total = items_sent + noise_sent;
            if (total < ITEM_TARGET / 3) begin
                src_idle_pct = 31;
                snk_idle_pct = 70;
            end else if (total < 2 * ITEM_TARGET / 3) begin
                src_idle_pct = 70;
                snk_idle_pct = 31;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if ($urandom_range(9) < 7 || ITEM_TARGET - total < LONG_ROOM) begin
                len = $urandom_range(12);
            end else begin
                case ($urandom_range(3))
                    0:       len = 55;
                    1:       len = 56;
                    2:       len = 63;
                    default: len = 64;
                endcase
            end
            send_message(len);
        end
        s_axis_tvalid <= 1'b0;

        // wait for every predicted digest word, then let the block settle
        while (words_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("run covered %0d messages from %0d input transactions plus %0d ignored ones",
                 messages_sent, items_sent, noise_sent);
        $display("%0d digest words compared, %0d errors", words_checked, error_count);
        if (error_count == 0 && words_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[files.f]
hdl/sha256_pkg.sv
hdl/sha256_dpath.sv
hdl/sha256_ctrl.sv
hdl/sha256_hash_engine_unit.sv
bench/sha256_digest_checker.sv
bench/tb_sha256_hash_engine_unit.sv
